>>> sv/gcc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the grid circle collision block.
// Depends on nothing; every other file refers to it by scoped names.
package gcc_pkg;

   localparam int GRID_COLUMNS     = 8;
   localparam int GRID_ROWS        = 6;
   localparam int CELL_CAPACITY    = 8;
   localparam int CELL_SIZE_PIXELS = 100;

   localparam int CELL_COUNT       = GRID_COLUMNS * GRID_ROWS;
   localparam int CELL_WIDTH_FIXED = CELL_SIZE_PIXELS * 16;
   localparam int ENTRY_COUNT      = CELL_COUNT * CELL_CAPACITY;

   localparam int ID_W     = 8;
   localparam int COORD_W  = 14;
   localparam int RADIUS_W = 12;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int ACC_W    = SQ_W + 1;

   localparam int CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int FILL_W = $clog2(CELL_CAPACITY + 1);
   localparam int SLOT_W = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
   localparam int ADDR_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int COL_W  = $clog2(GRID_COLUMNS + 1);
   localparam int ROW_W  = $clog2(GRID_ROWS + 1);

   localparam logic REQ_ADD       = 1'b0;
   localparam logic REQ_NEW_FRAME = 1'b1;

   localparam logic STATUS_PAIR     = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_FILL_RD,
      ST_FILL,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CMP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [RADIUS_W-1:0] r;
   } entry_type;

   typedef struct packed {
      logic              clear_all;
      logic              fill_rd;
      logic              write;
      logic              entry_rd;
      logic [CELL_W-1:0] cell_sel;
      logic [SLOT_W-1:0] rd_slot;
      logic [SLOT_W-1:0] wr_slot;
      logic [FILL_W-1:0] fill_val;
   } store_ctl_type;

   typedef struct packed {
      logic [SQ_W-1:0]  sq;
      logic [ACC_W-1:0] sum;
      logic             gt;
   } sq_result_type;

   // Column and row come from a thermometer of compares against cell edges;
   // a result equal to the grid size means the position lies outside.
   function automatic logic [COL_W-1:0] grid_col(input logic [COORD_W-1:0] v);
      logic [COL_W-1:0] c;
      c = '0;
      for (int k = 1; k <= GRID_COLUMNS; k++) begin
         if (32'(v) >= 32'(k * CELL_WIDTH_FIXED)) c = COL_W'(k);
      end
      return c;
   endfunction

   function automatic logic [ROW_W-1:0] grid_row(input logic [COORD_W-1:0] v);
      logic [ROW_W-1:0] c;
      c = '0;
      for (int k = 1; k <= GRID_ROWS; k++) begin
         if (32'(v) >= 32'(k * CELL_WIDTH_FIXED)) c = ROW_W'(k);
      end
      return c;
   endfunction

endpackage

>>> sv/gcc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response items.
// Depends on gcc_pkg for field widths.
interface gcc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [gcc_pkg::ID_W-1:0]     object_id;
   logic [gcc_pkg::COORD_W-1:0]  x_pos;
   logic [gcc_pkg::COORD_W-1:0]  y_pos;
   logic [gcc_pkg::RADIUS_W-1:0] circle_radius;
   logic                         alive;

   modport source (output valid, req_type, object_id, x_pos, y_pos, circle_radius, alive,
                   input ready);
   modport sink (input valid, req_type, object_id, x_pos, y_pos, circle_radius, alive,
                 output ready);
endinterface

interface gcc_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [gcc_pkg::ID_W-1:0] first_id;
   logic [gcc_pkg::ID_W-1:0] second_id;
   logic                     status;
   logic                     is_last;

   modport source (output valid, first_id, second_id, status, is_last, input ready);
   modport sink (input valid, first_id, second_id, status, is_last, output ready);
endinterface

>>> sv/gcc_sq_unit.sv
`timescale 1ns / 1ps
// Shared squaring unit: one multiplier with an accumulate adder and a compare.
// Depends on gcc_pkg.
module gcc_sq_unit (
   input  logic [gcc_pkg::COORD_W-1:0] operand,
   input  logic [gcc_pkg::ACC_W-1:0]   acc,
   output gcc_pkg::sq_result_type      result
);

   logic [gcc_pkg::SQ_W-1:0] sq;

   assign sq            = gcc_pkg::SQ_W'(operand) * gcc_pkg::SQ_W'(operand);
   assign result.sq     = sq;
   assign result.sum    = gcc_pkg::ACC_W'(sq) + acc;
   assign result.gt     = gcc_pkg::ACC_W'(sq) > acc;

endmodule

>>> sv/gcc_store.sv
`timescale 1ns / 1ps
// Cell storage: per-cell fill counts with valid bits, and the slot memory.
// Depends on gcc_pkg.
module gcc_store (
   input  logic                       clock,
   input  logic                       reset,
   input  gcc_pkg::store_ctl_type     ctl,
   input  gcc_pkg::entry_type         wr_entry,
   output logic [gcc_pkg::FILL_W-1:0] fill_rd,
   output gcc_pkg::entry_type         entry_rd
);

   logic [gcc_pkg::FILL_W-1:0]     fill_mem_ff [gcc_pkg::CELL_COUNT];
   logic [gcc_pkg::CELL_COUNT-1:0] fill_valid_ff;
   logic [gcc_pkg::FILL_W-1:0]     fill_rd_ff;
   logic                           fill_rd_valid_ff;
   gcc_pkg::entry_type             entry_mem_ff [gcc_pkg::ENTRY_COUNT];
   gcc_pkg::entry_type             entry_rd_ff;
   logic [gcc_pkg::ADDR_W-1:0]     rd_addr;
   logic [gcc_pkg::ADDR_W-1:0]     wr_addr;

   assign rd_addr = gcc_pkg::ADDR_W'(ctl.cell_sel) * gcc_pkg::ADDR_W'(gcc_pkg::CELL_CAPACITY)
                    + gcc_pkg::ADDR_W'(ctl.rd_slot);
   assign wr_addr = gcc_pkg::ADDR_W'(ctl.cell_sel) * gcc_pkg::ADDR_W'(gcc_pkg::CELL_CAPACITY)
                    + gcc_pkg::ADDR_W'(ctl.wr_slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_valid_ff <= '0;
      end else if (ctl.clear_all) begin
         fill_valid_ff <= '0;
      end else if (ctl.write) begin
         fill_valid_ff[ctl.cell_sel] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         fill_mem_ff[ctl.cell_sel] <= ctl.fill_val;
      end
      if (ctl.fill_rd) begin
         fill_rd_ff       <= fill_mem_ff[ctl.cell_sel];
         fill_rd_valid_ff <= fill_valid_ff[ctl.cell_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         entry_mem_ff[wr_addr] <= wr_entry;
      end
      if (ctl.entry_rd) begin
         entry_rd_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign fill_rd  = fill_rd_valid_ff ? fill_rd_ff : '0;
   assign entry_rd = entry_rd_ff;

endmodule

>>> sv/grid_circle_collision_pairs.sv
`timescale 1ns / 1ps
// An add item is located in the grid and its cell's fill count is read; then, for each
// object already stored in its cell, one squaring unit does dx squared, dy squared and the
// radius compare in turn, and a finishing step stores the item or reports an overflow. A
// dropped item (dead, zero coordinate or outside the grid) is not stored. The request side
// is ready only between items. A compare that finds a pair while another pair is pending,
// and a finishing step with a response to send, stall while the response register still
// holds an item that was not taken. Cell contents and fill counts are kept in memories, and
// a new frame empties all cells at once.
// Depends on gcc_pkg, gcc_if, gcc_sq_unit and gcc_store.
module grid_circle_collision_pairs (
   input  logic       clock,
   input  logic       reset,
   gcc_req_if.sink    req_if,
   gcc_rsp_if.source  rsp_if
);

   gcc_pkg::state_type             state_ff, state_in;
   logic [gcc_pkg::ID_W-1:0]       id_ff, id_in;
   logic [gcc_pkg::COORD_W-1:0]    x_ff, x_in;
   logic [gcc_pkg::COORD_W-1:0]    y_ff, y_in;
   logic [gcc_pkg::RADIUS_W-1:0]   r_ff, r_in;
   logic [gcc_pkg::CELL_W-1:0]     cell_ff, cell_in;
   logic [gcc_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [gcc_pkg::FILL_W-1:0]     idx_ff, idx_in;
   logic [gcc_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [gcc_pkg::ID_W-1:0]       pend_id_ff, pend_id_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [gcc_pkg::ID_W-1:0]       rsp_first_ff, rsp_first_in;
   logic [gcc_pkg::ID_W-1:0]       rsp_second_ff, rsp_second_in;
   logic                           rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   gcc_pkg::store_ctl_type         store_ctl;
   gcc_pkg::entry_type             wr_entry;
   gcc_pkg::entry_type             entry_rd;
   logic [gcc_pkg::FILL_W-1:0]     fill_rd;
   gcc_pkg::sq_result_type         sq_res;
   logic [gcc_pkg::COORD_W-1:0]    sq_operand;

   logic [gcc_pkg::COL_W-1:0]      col;
   logic [gcc_pkg::ROW_W-1:0]      row;
   logic [gcc_pkg::COORD_W-1:0]    dx;
   logic [gcc_pkg::COORD_W-1:0]    dy;
   logic [gcc_pkg::RADIUS_W:0]     rsum;
   logic [gcc_pkg::FILL_W-1:0]     idx_next;
   logic                           rsp_free;
   logic                           accept;

   gcc_sq_unit u_sq (
      .operand (sq_operand),
      .acc     (acc_ff),
      .result  (sq_res)
   );

   gcc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (store_ctl),
      .wr_entry (wr_entry),
      .fill_rd  (fill_rd),
      .entry_rd (entry_rd)
   );

   assign col      = gcc_pkg::grid_col(x_ff);
   assign row      = gcc_pkg::grid_row(y_ff);
   assign dx       = (x_ff > entry_rd.x) ? (x_ff - entry_rd.x) : (entry_rd.x - x_ff);
   assign dy       = (y_ff > entry_rd.y) ? (y_ff - entry_rd.y) : (entry_rd.y - y_ff);
   assign rsum     = (gcc_pkg::RADIUS_W+1)'(r_ff) + (gcc_pkg::RADIUS_W+1)'(entry_rd.r);
   assign idx_next = idx_ff + gcc_pkg::FILL_W'(1);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign accept   = req_if.valid && req_if.ready;

   assign wr_entry.id = id_ff;
   assign wr_entry.x  = x_ff;
   assign wr_entry.y  = y_ff;
   assign wr_entry.r  = r_ff;

   assign req_if.ready     = (state_ff == gcc_pkg::ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.first_id  = rsp_first_ff;
   assign rsp_if.second_id = rsp_second_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.is_last   = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gcc_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      r_ff          <= r_in;
      cell_ff       <= cell_in;
      fill_ff       <= fill_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      pend_id_ff    <= pend_id_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      id_in         = id_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      r_in          = r_ff;
      cell_in       = cell_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      sq_operand    = '0;

      store_ctl          = '0;
      store_ctl.cell_sel = cell_ff;
      store_ctl.rd_slot  = idx_ff[gcc_pkg::SLOT_W-1:0];
      store_ctl.wr_slot  = fill_ff[gcc_pkg::SLOT_W-1:0];
      store_ctl.fill_val = fill_ff + gcc_pkg::FILL_W'(1);

      case (state_ff)
         gcc_pkg::ST_IDLE: begin
            if (accept) begin
               id_in = req_if.object_id;
               x_in  = req_if.x_pos;
               y_in  = req_if.y_pos;
               r_in  = req_if.circle_radius;
               if (req_if.req_type == gcc_pkg::REQ_NEW_FRAME) begin
                  store_ctl.clear_all = 1'b1;
               end else if (req_if.alive && (req_if.x_pos != '0) && (req_if.y_pos != '0)) begin
                  state_in = gcc_pkg::ST_LOCATE;
               end
            end
         end
         gcc_pkg::ST_LOCATE: begin
            if ((32'(col) >= gcc_pkg::GRID_COLUMNS) || (32'(row) >= gcc_pkg::GRID_ROWS)) begin
               state_in = gcc_pkg::ST_IDLE;
            end else begin
               cell_in  = gcc_pkg::CELL_W'(32'(row) * gcc_pkg::GRID_COLUMNS + 32'(col));
               state_in = gcc_pkg::ST_FILL_RD;
            end
         end
         gcc_pkg::ST_FILL_RD: begin
            store_ctl.fill_rd = 1'b1;
            state_in          = gcc_pkg::ST_FILL;
         end
         gcc_pkg::ST_FILL: begin
            fill_in            = fill_rd;
            idx_in             = '0;
            store_ctl.entry_rd = 1'b1;
            store_ctl.rd_slot  = '0;
            state_in = (fill_rd == '0) ? gcc_pkg::ST_FINISH : gcc_pkg::ST_SQ_X;
         end
         gcc_pkg::ST_SQ_X: begin
            sq_operand = dx;
            acc_in     = gcc_pkg::ACC_W'(sq_res.sq);
            state_in   = gcc_pkg::ST_SQ_Y;
         end
         gcc_pkg::ST_SQ_Y: begin
            sq_operand = dy;
            acc_in     = sq_res.sum;
            state_in   = gcc_pkg::ST_CMP;
         end
         gcc_pkg::ST_CMP: begin
            sq_operand = gcc_pkg::COORD_W'(rsum);
            if (!(sq_res.gt && pend_valid_ff && !rsp_free)) begin
               if (sq_res.gt) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_first_in  = id_ff;
                     rsp_second_in = pend_id_ff;
                     rsp_status_in = gcc_pkg::STATUS_PAIR;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = entry_rd.id;
               end
               idx_in = idx_next;
               if (idx_next == fill_ff) begin
                  state_in = gcc_pkg::ST_FINISH;
               end else begin
                  store_ctl.entry_rd = 1'b1;
                  store_ctl.rd_slot  = idx_next[gcc_pkg::SLOT_W-1:0];
                  state_in           = gcc_pkg::ST_SQ_X;
               end
            end
         end
         gcc_pkg::ST_FINISH: begin
            if (32'(fill_ff) >= gcc_pkg::CELL_CAPACITY) begin
               if (rsp_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_first_in = id_ff;
                  if (pend_valid_ff) begin
                     rsp_second_in = pend_id_ff;
                     rsp_status_in = gcc_pkg::STATUS_PAIR;
                     rsp_last_in   = 1'b0;
                     pend_valid_in = 1'b0;
                  end else begin
                     rsp_second_in = '0;
                     rsp_status_in = gcc_pkg::STATUS_OVERFLOW;
                     rsp_last_in   = 1'b1;
                     state_in      = gcc_pkg::ST_IDLE;
                  end
               end
            end else begin
               // Rewriting the same slot and count while stalled is harmless.
               store_ctl.write = 1'b1;
               if (!pend_valid_ff) begin
                  state_in = gcc_pkg::ST_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_first_in  = id_ff;
                  rsp_second_in = pend_id_ff;
                  rsp_status_in = gcc_pkg::STATUS_PAIR;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = gcc_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = gcc_pkg::ST_IDLE;
         end
      endcase
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcc_pkg::ST_IDLE) |-> !pend_valid_ff)
      else $error("pending pair left behind when returning to idle");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcc_pkg::ST_SQ_X) |-> (idx_ff < fill_ff))
      else $error("slot walk went past the cell fill count");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcc_pkg::ST_FINISH) |-> (32'(fill_ff) <= gcc_pkg::CELL_CAPACITY))
      else $error("cell fill count above capacity");

   a_overflow_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == gcc_pkg::STATUS_OVERFLOW)) |-> rsp_last_ff)
      else $error("overflow item not marked as last");

   a_squares_follow_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gcc_pkg::ST_SQ_Y) |-> ($past(state_ff) == gcc_pkg::ST_SQ_X))
      else $error("squaring sequence out of order");

endmodule

>>> verif/tb_grid_circle_collision_pairs.sv
`timescale 1ns / 1ps
// Self-checking testbench for grid_circle_collision_pairs: a table of directed items, then
// random circles aimed at a few busy cells; most checks use a grid-and-pair predictor.
// Depends on gcc_pkg, gcc_if and the RTL of grid_circle_collision_pairs.
module tb_grid_circle_collision_pairs;

   localparam int RANDOM_ITEMS = 447;
   localparam int MAX_WAIT     = 13;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   localparam logic ADD   = gcc_pkg::REQ_ADD;
   localparam logic FRAME = gcc_pkg::REQ_NEW_FRAME;
   localparam logic PAIR  = gcc_pkg::STATUS_PAIR;
   localparam logic OVF   = gcc_pkg::STATUS_OVERFLOW;

   typedef enum logic [1:0] {
      CHK_MODEL,
      CHK_NONE,
      CHK_ONE
   } row_check_type;

   typedef struct packed {
      logic                         req_type;
      logic [gcc_pkg::ID_W-1:0]     id;
      logic [gcc_pkg::COORD_W-1:0]  x;
      logic [gcc_pkg::COORD_W-1:0]  y;
      logic [gcc_pkg::RADIUS_W-1:0] r;
      logic                         alive;
      row_check_type                check;
      logic [gcc_pkg::ID_W-1:0]     want_second;
      logic                         want_status;
   } stim_row_type;

   typedef struct packed {
      logic [gcc_pkg::ID_W-1:0] first_id;
      logic [gcc_pkg::ID_W-1:0] second_id;
      logic                     status;
      logic                     is_last;
   } pair_rsp_type;

   logic clock = 1'b0;
   logic reset;

   gcc_req_if req_ch ();
   gcc_rsp_if rsp_ch ();

   grid_circle_collision_pairs uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [gcc_pkg::FILL_W-1:0]   cell_load [gcc_pkg::CELL_COUNT];
   logic [gcc_pkg::ID_W-1:0]     slot_id   [gcc_pkg::CELL_COUNT][gcc_pkg::CELL_CAPACITY];
   logic [gcc_pkg::COORD_W-1:0]  slot_x    [gcc_pkg::CELL_COUNT][gcc_pkg::CELL_CAPACITY];
   logic [gcc_pkg::COORD_W-1:0]  slot_y    [gcc_pkg::CELL_COUNT][gcc_pkg::CELL_CAPACITY];
   logic [gcc_pkg::RADIUS_W-1:0] slot_r    [gcc_pkg::CELL_COUNT][gcc_pkg::CELL_CAPACITY];

   stim_row_type directed_plan [$];
   stim_row_type in_flight [$];
   pair_rsp_type predicted [$];
   pair_rsp_type expected_pairs [$];

   logic calm = 1'b0;
   int   error_count = 0;
   int   items_accepted = 0;
   int   frames_seen = 0;
   int   pairs_seen = 0;
   int   overflows_seen = 0;
   int   cycle_count = 0;

   // Sorts one request into the grid and lists the pairs and overflow it should cause.
   function automatic void predict_pairs(input logic kind,
                                         input logic [gcc_pkg::ID_W-1:0] id,
                                         input logic [gcc_pkg::COORD_W-1:0] x,
                                         input logic [gcc_pkg::COORD_W-1:0] y,
                                         input logic [gcc_pkg::RADIUS_W-1:0] r,
                                         input logic live);
      int           col;
      int           row;
      int           cell_ix;
      int           load;
      logic [63:0]  dx;
      logic [63:0]  dy;
      logic [63:0]  rs;
      pair_rsp_type entry;
      predicted.delete();
      if (kind == FRAME) begin
         foreach (cell_load[c]) cell_load[c] = '0;
         return;
      end
      if (!live || x == 0 || y == 0) return;
      col = int'(x) / gcc_pkg::CELL_WIDTH_FIXED;
      row = int'(y) / gcc_pkg::CELL_WIDTH_FIXED;
      if (col >= gcc_pkg::GRID_COLUMNS || row >= gcc_pkg::GRID_ROWS) return;
      cell_ix = row * gcc_pkg::GRID_COLUMNS + col;
      load = int'(cell_load[cell_ix]);
      for (int s = 0; s < load; s++) begin
         dx = (slot_x[cell_ix][s] > x) ? 64'(slot_x[cell_ix][s] - x)
                                       : 64'(x - slot_x[cell_ix][s]);
         dy = (slot_y[cell_ix][s] > y) ? 64'(slot_y[cell_ix][s] - y)
                                       : 64'(y - slot_y[cell_ix][s]);
         rs = 64'(slot_r[cell_ix][s]) + 64'(r);
         if (rs * rs > dx * dx + dy * dy) begin
            entry = '{id, slot_id[cell_ix][s], PAIR, 1'b0};
            predicted.insert(predicted.size(), entry);
         end
      end
      if (load >= gcc_pkg::CELL_CAPACITY) begin
         entry = '{id, {gcc_pkg::ID_W{1'b0}}, OVF, 1'b0};
         predicted.insert(predicted.size(), entry);
      end else begin
         slot_id[cell_ix][load] = id;
         slot_x[cell_ix][load] = x;
         slot_y[cell_ix][load] = y;
         slot_r[cell_ix][load] = r;
         cell_load[cell_ix] = gcc_pkg::FILL_W'(load + 1);
      end
      if (predicted.size() > 0) predicted[predicted.size()-1].is_last = 1'b1;
   endfunction

   // Appends one row to the directed table.
   function automatic void plan_row(input logic kind, input int id, input int x, input int y,
                                    input int r, input logic live, input row_check_type check,
                                    input int second, input logic status);
      stim_row_type line;
      line = '{kind, gcc_pkg::ID_W'(id), gcc_pkg::COORD_W'(x), gcc_pkg::COORD_W'(y),
               gcc_pkg::RADIUS_W'(r), live, check, gcc_pkg::ID_W'(second), status};
      directed_plan.insert(directed_plan.size(), line);
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(MAX_WAIT);
   endfunction

   // Mostly well-formed adds aimed at two busy cells, with some new frames and noise.
   function automatic stim_row_type draw_circle();
      stim_row_type item;
      int           pick;
      int           hot;
      int           col;
      int           row;
      item = '{ADD, 8'd0, 14'd0, 14'd0, 12'd0, 1'b1, CHK_MODEL, 8'd0, PAIR};
      item.id = gcc_pkg::ID_W'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 3) begin
         item.req_type = FRAME;
         item.x = gcc_pkg::COORD_W'($urandom_range(16383));
         item.y = gcc_pkg::COORD_W'($urandom_range(16383));
         item.r = gcc_pkg::RADIUS_W'($urandom_range(4095));
         item.alive = 1'($urandom_range(1));
      end else if (pick < 13) begin
         item.x = ($urandom_range(3) == 0) ? '0 : gcc_pkg::COORD_W'($urandom_range(16383));
         item.y = ($urandom_range(3) == 0) ? '0 : gcc_pkg::COORD_W'($urandom_range(16383));
         item.r = gcc_pkg::RADIUS_W'($urandom_range(4095));
         item.alive = 1'($urandom_range(1));
      end else begin
         hot = $urandom_range(9);
         if (hot < 4) begin
            col = 0;
            row = 0;
         end else if (hot < 7) begin
            col = gcc_pkg::GRID_COLUMNS - 1;
            row = gcc_pkg::GRID_ROWS - 1;
         end else begin
            col = $urandom_range(gcc_pkg::GRID_COLUMNS - 1);
            row = $urandom_range(gcc_pkg::GRID_ROWS - 1);
         end
         item.x = gcc_pkg::COORD_W'(col * gcc_pkg::CELL_WIDTH_FIXED
                  + $urandom_range(gcc_pkg::CELL_WIDTH_FIXED - 1, (col == 0) ? 1 : 0));
         item.y = gcc_pkg::COORD_W'(row * gcc_pkg::CELL_WIDTH_FIXED
                  + $urandom_range(gcc_pkg::CELL_WIDTH_FIXED - 1, (row == 0) ? 1 : 0));
         item.r = ($urandom_range(2) == 0) ? gcc_pkg::RADIUS_W'($urandom_range(4095))
                                           : gcc_pkg::RADIUS_W'($urandom_range(400));
      end
      return item;
   endfunction

   task automatic send_item(input stim_row_type item);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.req_type      <= item.req_type;
      req_ch.object_id     <= item.id;
      req_ch.x_pos         <= item.x;
      req_ch.y_pos         <= item.y;
      req_ch.circle_radius <= item.r;
      req_ch.alive         <= item.alive;
      req_ch.valid         <= 1'b1;
      in_flight.insert(in_flight.size(), item);
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   always @(posedge clock) begin : score
      pair_rsp_type got;
      pair_rsp_type want;
      stim_row_type item;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.first_id, rsp_ch.second_id, rsp_ch.status, rsp_ch.is_last};
            if (got.status == OVF) overflows_seen++;
            else pairs_seen++;
            if (expected_pairs.size() == 0) begin
               error_count++;
               $display("%0t: expected nothing, actual %0d %0d %0d %0d",
                        $time, got.first_id, got.second_id, got.status, got.is_last);
            end else begin
               want = expected_pairs.pop_front();
               if (got.first_id !== want.first_id || got.second_id !== want.second_id ||
                   got.status !== want.status || got.is_last !== want.is_last) begin
                  error_count++;
                  $display("%0t: expected %0d %0d %0d %0d, actual %0d %0d %0d %0d",
                           $time, want.first_id, want.second_id, want.status, want.is_last,
                           got.first_id, got.second_id, got.status, got.is_last);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            item = in_flight.pop_front();
            items_accepted++;
            if (req_ch.req_type == FRAME) frames_seen++;
            predict_pairs(req_ch.req_type, req_ch.object_id, req_ch.x_pos, req_ch.y_pos,
                          req_ch.circle_radius, req_ch.alive);
            case (item.check)
               CHK_MODEL: begin
                  foreach (predicted[k]) expected_pairs.insert(expected_pairs.size(),
                                                               predicted[k]);
               end
               CHK_ONE: begin
                  want = '{req_ch.object_id, item.want_second, item.want_status, 1'b1};
                  expected_pairs.insert(expected_pairs.size(), want);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: no progress after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, expected_pairs.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin : drain_side
         int stall;
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = ADD;
      req_ch.object_id = '0;
      req_ch.x_pos = '0;
      req_ch.y_pos = '0;
      req_ch.circle_radius = '0;
      req_ch.alive = 1'b0;
      foreach (cell_load[c]) cell_load[c] = '0;

      plan_row(FRAME, 0, 0, 0, 0, 1'b0, CHK_NONE, 0, PAIR);
      plan_row(ADD, 1, 800, 800, 100, 1'b0, CHK_NONE, 0, PAIR);
      plan_row(ADD, 2, 0, 800, 100, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 3, 800, 0, 100, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 4, 12800, 800, 100, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 5, 800, 9600, 100, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 6, 16383, 16383, 4095, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 255, 1, 1, 4095, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 0, 1599, 1599, 0, 1'b1, CHK_ONE, 255, PAIR);
      plan_row(ADD, 20, 3201, 1, 16, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 21, 3233, 1, 16, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 22, 3232, 1, 16, 1'b1, CHK_MODEL, 0, PAIR);
      for (int k = 0; k < gcc_pkg::CELL_CAPACITY; k++)
         plan_row(ADD, 10 + k, 11201 + 100 * k, 8001 + 100 * k, 0, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 18, 12799, 9599, 0, 1'b1, CHK_ONE, 0, OVF);
      plan_row(ADD, 19, 12000, 8800, 4095, 1'b1, CHK_MODEL, 0, PAIR);
      plan_row(FRAME, 170, 10922, 5461, 4095, 1'b1, CHK_NONE, 0, PAIR);
      plan_row(ADD, 23, 12799, 9599, 4095, 1'b1, CHK_NONE, 0, PAIR);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) send_item(directed_plan[k]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 120 && n < 200) || (n >= 350 && n < 390);
         send_item(draw_circle());
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      while (in_flight.size() != 0 || expected_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d items with %0d new frames, %0d overlap pairs and %0d overflows.",
               items_accepted, frames_seen, pairs_seen, overflows_seen);
      $display("%0d mismatches found in %0d cycles.", error_count, cycle_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> grid_circle_collision_pairs.f
sv/gcc_pkg.sv
sv/gcc_if.sv
sv/gcc_sq_unit.sv
sv/gcc_store.sv
sv/grid_circle_collision_pairs.sv
verif/tb_grid_circle_collision_pairs.sv
